FILE: hw/rtl/fsub_pkg.sv
// -----------------------------------------------------------------------------
// fsub_pkg
// Shared types and constants for the first substring match core.
// -----------------------------------------------------------------------------
package fsub_pkg;

    // Pattern store and active vector geometry
    localparam int MAX_PATTERN = 64;
    localparam int VEC_BITS    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int LEN_W       = 7;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 32;

    // Effective length saturation value
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    // Input modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Register select, taken from paddr[2]
    localparam logic REG_PATTERN_LEN   = 1'b0;
    localparam logic REG_POSITION_BASE = 1'b1;

    // One classified text byte, passed from front to back
    typedef struct packed {
        logic [VEC_BITS-1:0] char_mask;
        logic                last_byte;
    } t_text_item;

endpackage

FILE: hw/rtl/fsub_front.sv
// -----------------------------------------------------------------------------
// fsub_front
// Accepts items, writes pattern bytes, and turns text bytes into char masks.
// -----------------------------------------------------------------------------
module fsub_front (
    input  logic                                 i_clk,
    input  logic                                 i_in_valid,
    input  logic                                 i_mode,
    input  logic [7:0]                           i_data_byte,
    input  logic [fsub_pkg::IDX_W-1:0]           i_pattern_index,
    input  logic                                 i_last_byte,
    input  logic                                 i_q_full,
    output logic                                 o_in_ready,
    output logic                                 o_push,
    output fsub_pkg::t_text_item                 o_item
);

    logic [7:0] r_store [fsub_pkg::STORE_DEPTH];
    logic       w_accept;

    // Accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // Write pattern byte on a load transfer
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == fsub_pkg::MODE_LOAD)) begin
            r_store[i_pattern_index] <= i_data_byte;
        end
    end

    // Compare the text byte against every store entry in parallel
    always_comb begin
        for (int j = 0; j < fsub_pkg::VEC_BITS; j++) begin
            o_item.char_mask[j] = (r_store[j] == i_data_byte);
        end
        o_item.last_byte = i_last_byte;
    end

    // Push only text bytes toward the back
    assign o_push = w_accept && (i_mode == fsub_pkg::MODE_SEARCH);

endmodule

FILE: hw/rtl/fsub_queue.sv
// -----------------------------------------------------------------------------
// fsub_queue
// Two-entry queue of classified text bytes between front and back.
// -----------------------------------------------------------------------------
module fsub_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fsub_pkg::t_text_item i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output fsub_pkg::t_text_item o_item
);

    fsub_pkg::t_text_item r_slot [2];
    logic                 r_head;
    logic [1:0]           r_count;
    logic                 n_head;
    logic [1:0]           n_count;
    logic                 w_tail;

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_head];
    assign w_tail  = r_head ^ r_count[0];

    // Advance head and count
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_pop) begin
            n_head = !r_head;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Hold payload in the tail slot
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[w_tail] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/fsub_back.sv
// -----------------------------------------------------------------------------
// fsub_back
// Shift-and update per text byte and the registered result stage.
// -----------------------------------------------------------------------------
module fsub_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  fsub_pkg::t_text_item                 i_item,
    input  logic [fsub_pkg::LEN_W-1:0]           i_pattern_len,
    input  logic [fsub_pkg::POS_W-1:0]           i_position_base,
    input  logic                                 i_out_ready,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    output logic                                 o_found,
    output logic [fsub_pkg::POS_W-1:0]           o_position
);

    logic [fsub_pkg::VEC_BITS-1:0] r_active;
    logic [fsub_pkg::POS_W-1:0]    r_text_count;
    logic                          r_reported;
    logic                          r_out_valid;
    logic                          r_found;
    logic [fsub_pkg::POS_W-1:0]    r_position;

    logic [fsub_pkg::VEC_BITS-1:0] n_active;
    logic [fsub_pkg::POS_W-1:0]    n_text_count;
    logic                          n_reported;
    logic                          n_out_valid;
    logic                          n_found;
    logic [fsub_pkg::POS_W-1:0]    n_position;

    logic [fsub_pkg::LEN_W-1:0]    w_len;
    logic [fsub_pkg::LEN_W-1:0]    w_len_m1;
    logic [fsub_pkg::VEC_BITS-1:0] w_live;
    logic [fsub_pkg::VEC_BITS-1:0] w_next_vec;
    logic [fsub_pkg::POS_W-1:0]    w_start;
    logic                          w_hit;

    // Saturate the length and build the live mask
    assign w_len    = (i_pattern_len > fsub_pkg::LEN_MAX) ? fsub_pkg::LEN_MAX
                                                          : i_pattern_len;
    assign w_len_m1 = w_len - fsub_pkg::LEN_W'(1);
    assign w_live   = w_len[fsub_pkg::LEN_W-1] ? '1
                    : ((fsub_pkg::VEC_BITS'(1) << w_len[fsub_pkg::IDX_W-1:0])
                       - fsub_pkg::VEC_BITS'(1));

    // Shift-and step and match test
    assign w_next_vec = {r_active[fsub_pkg::VEC_BITS-2:0], 1'b1}
                        & i_item.char_mask & w_live;
    assign w_hit      = (w_len != '0) && w_next_vec[w_len_m1[fsub_pkg::IDX_W-1:0]];
    assign w_start    = r_text_count + fsub_pkg::POS_W'(1)
                        - fsub_pkg::POS_W'(w_len);

    // Pop when the result register is free at this edge
    assign o_pop = i_q_valid && (!r_out_valid || i_out_ready);

    // Next search state and result
    always_comb begin
        n_active     = r_active;
        n_text_count = r_text_count;
        n_reported   = r_reported;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_found      = r_found;
        n_position   = r_position;
        if (o_pop) begin
            if (!r_reported) begin
                n_text_count = r_text_count + fsub_pkg::POS_W'(1);
                if (w_len == '0) begin
                    n_reported  = 1'b1;
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_position  = i_position_base;
                end else begin
                    n_active = w_next_vec;
                    if (w_hit) begin
                        n_reported  = 1'b1;
                        n_out_valid = 1'b1;
                        n_found     = 1'b1;
                        n_position  = i_position_base + w_start;
                    end
                end
            end
            if (i_item.last_byte) begin
                // Report not-found if this search gave nothing
                if (!n_reported) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_position  = '0;
                end
                n_active     = '0;
                n_text_count = '0;
                n_reported   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_text_count <= '0;
            r_reported   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_text_count <= n_text_count;
            r_reported   <= n_reported;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_found    <= n_found;
        r_position <= n_position;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

endmodule

FILE: hw/rtl/first_substring_match_core.sv
// -----------------------------------------------------------------------------
// first_substring_match_core
// Streaming exact substring search with a bit-parallel shift-and vector.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready   | mode, data_byte,
//           |           |                           | pattern_index, last_byte
//   out     | output    | o_out_valid / i_out_ready | found, position
//   cfg     | input     | APB psel/penable, pready  | pattern_len, position_base
//
// One item is taken per cycle while the queue has room. The compare lands in
// the queue at the transfer edge and the shift-and step lands in the result reg
// when the back pops the item, which waits while a stalled result is held.
// The 64 parallel byte compares and the one-step vector update set this rate.
// Synchronous active-low reset clears the queue, search state and result valid.
// A stalled output backs up into the two-entry queue, then drops o_in_ready.
// -----------------------------------------------------------------------------
module first_substring_match_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [7:0]                    i_data_byte,
    input  logic [fsub_pkg::IDX_W-1:0]    i_pattern_index,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [fsub_pkg::POS_W-1:0]    o_position,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [fsub_pkg::LEN_W-1:0] r_pattern_len;
    logic [fsub_pkg::POS_W-1:0] r_position_base;

    logic                 w_push;
    logic                 w_pop;
    logic                 w_q_full;
    logic                 w_q_valid;
    fsub_pkg::t_text_item w_front_item;
    fsub_pkg::t_text_item w_back_item;
    logic                 w_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len   <= '0;
            r_position_base <= '0;
        end else if (w_wr) begin
            unique case (paddr[2])
                fsub_pkg::REG_PATTERN_LEN:   r_pattern_len   <= pwdata[fsub_pkg::LEN_W-1:0];
                fsub_pkg::REG_POSITION_BASE: r_position_base <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[2])
            fsub_pkg::REG_PATTERN_LEN:   prdata = 32'(r_pattern_len);
            fsub_pkg::REG_POSITION_BASE: prdata = r_position_base;
            default:                     prdata = '0;
        endcase
    end

    fsub_front u_front (
        .i_clk           (i_clk),
        .i_in_valid      (i_in_valid),
        .i_mode          (i_mode),
        .i_data_byte     (i_data_byte),
        .i_pattern_index (i_pattern_index),
        .i_last_byte     (i_last_byte),
        .i_q_full        (w_q_full),
        .o_in_ready      (o_in_ready),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    fsub_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_back_item)
    );

    fsub_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_item          (w_back_item),
        .i_pattern_len   (r_pattern_len),
        .i_position_base (r_position_base),
        .i_out_ready     (i_out_ready),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .o_found         (o_found),
        .o_position      (o_position)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for first_substring_match_core. A shift-and predictor
// tracks the pattern store, active vector and search position for every input
// transfer and queues the expected match results. A monitor checks each output
// transfer against that queue. Directed tests cover the empty pattern, byte
// extremes, mid-search loads and length changes, position wrap and length
// saturation. Random searches with planted matches then run under four idle
// and stall mixes.
// -----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 130;

    localparam logic [2:0] ADDR_PATTERN_LEN   = {fsub_pkg::REG_PATTERN_LEN, 2'b00};
    localparam logic [2:0] ADDR_POSITION_BASE = {fsub_pkg::REG_POSITION_BASE, 2'b00};

    typedef struct packed {
        logic                       found;
        logic [fsub_pkg::POS_W-1:0] position;
    } t_search_result;

    // Block ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_mode = fsub_pkg::MODE_LOAD;
    logic [7:0]                  i_data_byte = 8'h00;
    logic [fsub_pkg::IDX_W-1:0]  i_pattern_index = '0;
    logic                        i_last_byte = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b1;
    logic                        o_found;
    logic [fsub_pkg::POS_W-1:0]  o_position;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [2:0]                  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Predictor state
    logic [7:0]                    pat_mem [0:fsub_pkg::STORE_DEPTH-1];
    logic [fsub_pkg::VEC_BITS-1:0] active_vec = '0;
    logic [31:0]                   text_idx = '0;
    logic                          reported = 1'b0;
    logic [fsub_pkg::LEN_W-1:0]    len_reg = '0;
    logic [fsub_pkg::POS_W-1:0]    base_reg = '0;

    t_search_result match_q[$];
    t_search_result want;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int err_cnt = 0;
    int n_items = 0;
    int n_found = 0;
    int n_missed = 0;
    int n_writes = 0;
    int cycle_cnt = 0;

    first_substring_match_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_data_byte     (i_data_byte),
        .i_pattern_index (i_pattern_index),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_position      (o_position),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycle_cnt, match_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random backpressure on the result channel
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (match_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual found=%0b position=%h",
                         $time, o_found, o_position);
                err_cnt++;
            end else begin
                want = match_q.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, want.found, o_found);
                    err_cnt++;
                end
                if (o_position !== want.position) begin
                    $display("%0t: position mismatch, expected %h actual %h",
                             $time, want.position, o_position);
                    err_cnt++;
                end
                if (want.found) n_found++;
                else n_missed++;
            end
        end
    end

    // Advance the shift-and search by one accepted item
    task automatic shift_and_step(input logic mode_v, input logic [7:0] data_v,
                                  input logic [fsub_pkg::IDX_W-1:0] idx_v,
                                  input logic last_v);
        int unsigned                   eff;
        logic [fsub_pkg::VEC_BITS-1:0] char_bits;
        logic [fsub_pkg::VEC_BITS-1:0] live;
        t_search_result                res;
        if (mode_v == fsub_pkg::MODE_LOAD) begin
            pat_mem[idx_v] = data_v;
        end else begin
            if (!reported) begin
                eff = (len_reg > fsub_pkg::MAX_PATTERN) ? fsub_pkg::MAX_PATTERN : len_reg;
                if (eff == 0) begin
                    // empty pattern matches at the first byte
                    res.found = 1'b1;
                    res.position = base_reg;
                    match_q.push_back(res);
                    reported = 1'b1;
                end else begin
                    char_bits = '0;
                    for (int j = 0; j < eff; j++) begin
                        if (pat_mem[j] == data_v) char_bits[j] = 1'b1;
                    end
                    live = (eff >= fsub_pkg::VEC_BITS) ? '1 : ((64'd1 << eff) - 64'd1);
                    active_vec = ((active_vec << 1) | 64'd1) & char_bits & live;
                    if (active_vec[eff-1]) begin
                        res.found = 1'b1;
                        res.position = base_reg + text_idx + 32'd1 - 32'(eff);
                        match_q.push_back(res);
                        reported = 1'b1;
                    end
                end
                text_idx = text_idx + 32'd1;
            end
            // close the search, reporting a miss if nothing was found
            if (last_v) begin
                if (!reported) begin
                    res.found = 1'b0;
                    res.position = '0;
                    match_q.push_back(res);
                end
                active_vec = '0;
                text_idx = '0;
                reported = 1'b0;
            end
        end
    endtask

    // Present one item, hold it until transfer, then predict
    task automatic send_item(input logic mode_v, input logic [7:0] data_v,
                             input logic [fsub_pkg::IDX_W-1:0] idx_v,
                             input logic last_v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode_v;
        i_data_byte     <= data_v;
        i_pattern_index <= idx_v;
        i_last_byte     <= last_v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shift_and_step(mode_v, data_v, idx_v, last_v);
        n_items++;
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then idle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PATTERN_LEN) len_reg = value[fsub_pkg::LEN_W-1:0];
        else base_reg = value;
        n_writes++;
        @(posedge i_clk);
    endtask

    // Empty pattern: first byte matches, later bytes ignored until last
    task automatic test_empty_pattern();
        write_reg(ADDR_PATTERN_LEN, 32'd0);
        write_reg(ADDR_POSITION_BASE, 32'h0000_1000);
        send_item(fsub_pkg::MODE_SEARCH, 8'h41, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h42, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h43, '0, 1'b1);
        send_item(fsub_pkg::MODE_SEARCH, 8'h44, '0, 1'b1);
        wait_idle();
    endtask

    // Byte extremes, last flag ignored on loads, a hit and a miss
    task automatic test_basic_match();
        send_item(fsub_pkg::MODE_LOAD, 8'h00, 6'd0, 1'b1);
        send_item(fsub_pkg::MODE_LOAD, 8'hFF, 6'd1, 1'b0);
        send_item(fsub_pkg::MODE_LOAD, 8'hA5, 6'd63, 1'b1);
        wait_idle();
        write_reg(ADDR_PATTERN_LEN, 32'd2);
        write_reg(ADDR_POSITION_BASE, 32'd0);
        send_item(fsub_pkg::MODE_SEARCH, 8'hFF, 6'd63, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h00, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'hFF, '0, 1'b1);
        send_item(fsub_pkg::MODE_SEARCH, 8'h00, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h00, '0, 1'b1);
        wait_idle();
    endtask

    // Load and length change mid-search, then position wrap
    task automatic test_mid_search();
        send_item(fsub_pkg::MODE_SEARCH, 8'h00, '0, 1'b0);
        send_item(fsub_pkg::MODE_LOAD, 8'h11, 6'd2, 1'b0);
        wait_idle();
        write_reg(ADDR_PATTERN_LEN, 32'd3);
        send_item(fsub_pkg::MODE_SEARCH, 8'hFF, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h11, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h22, '0, 1'b1);
        wait_idle();
        write_reg(ADDR_PATTERN_LEN, 32'd1);
        write_reg(ADDR_POSITION_BASE, 32'hFFFF_FFFF);
        send_item(fsub_pkg::MODE_SEARCH, 8'h7F, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h80, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h00, '0, 1'b0);
        send_item(fsub_pkg::MODE_SEARCH, 8'h01, '0, 1'b1);
        wait_idle();
    endtask

    // Write every store entry with random content
    task automatic test_fill_store();
        for (int j = 0; j < fsub_pkg::STORE_DEPTH; j++) begin
            send_item(fsub_pkg::MODE_LOAD, 8'($urandom_range(255)),
                      fsub_pkg::IDX_W'(j), 1'($urandom_range(1)));
        end
        wait_idle();
    endtask

    // Full-width pattern, including lengths that saturate
    task automatic test_long_pattern();
        logic [7:0] text_b;
        send_idle_pct = 33;
        stall_pct = 33;
        for (int s = 0; s < 3; s++) begin
            wait_idle();
            write_reg(ADDR_PATTERN_LEN, (s == 0) ? 32'd64 : (s == 1) ? 32'd127 : 32'd100);
            write_reg(ADDR_POSITION_BASE, (s == 2) ? 32'hFFFF_FFF0 : 32'd0);
            send_item(fsub_pkg::MODE_SEARCH, 8'($urandom_range(255)), '0, 1'b0);
            send_item(fsub_pkg::MODE_SEARCH, 8'($urandom_range(255)), '0, 1'b0);
            for (int j = 0; j < fsub_pkg::VEC_BITS; j++) begin
                text_b = pat_mem[j];
                // break the copy once to force a miss
                if (s == 1 && j == 40) text_b = ~text_b;
                send_item(fsub_pkg::MODE_SEARCH, text_b, '0, j == fsub_pkg::VEC_BITS - 1);
            end
        end
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // One random search: optional reconfig, optional reload, text with a
    // planted copy of the pattern most of the time
    task automatic run_round();
        int unsigned pick;
        int unsigned eff_len;
        int unsigned text_len;
        int unsigned plant_at;
        int unsigned alpha_lo;
        int unsigned alpha_span;
        logic [7:0]  text_q[$];
        bit          keep_open;
        if ($urandom_range(1) == 0) begin
            pick = $urandom_range(99);
            if (pick < 6) eff_len = 0;
            else if (pick < 12) eff_len = $urandom_range(64, 33);
            else eff_len = $urandom_range(8, 1);
            wait_idle();
            if (eff_len == 64 && $urandom_range(1) == 1)
                write_reg(ADDR_PATTERN_LEN, $urandom_range(127, 65));
            else
                write_reg(ADDR_PATTERN_LEN, eff_len);
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(1) == 0)
                    write_reg(ADDR_POSITION_BASE, 32'hFFFF_FFFF - $urandom_range(40));
                else
                    write_reg(ADDR_POSITION_BASE, $urandom());
            end
        end
        eff_len = (len_reg > fsub_pkg::MAX_PATTERN) ? fsub_pkg::MAX_PATTERN : len_reg;

        // small alphabet most of the time so partial matches are common
        if ($urandom_range(3) == 0) begin
            alpha_lo = 0;
            alpha_span = 255;
        end else begin
            alpha_span = $urandom_range(2, 1);
            alpha_lo = $urandom_range(255 - alpha_span);
        end

        if ($urandom_range(9) < 7) begin
            for (int j = 0; j < eff_len; j++) begin
                send_item(fsub_pkg::MODE_LOAD, 8'(alpha_lo + $urandom_range(alpha_span)),
                          fsub_pkg::IDX_W'(j), 1'($urandom_range(1)));
            end
        end

        // build the text, planting the pattern at a random offset
        text_len = $urandom_range(16, 1);
        if (eff_len > 0 && $urandom_range(9) < 6) begin
            text_len += eff_len;
            plant_at = $urandom_range(text_len - eff_len);
        end else begin
            plant_at = text_len;
        end
        for (int k = 0; k < text_len; k++) begin
            if (k >= plant_at && k < plant_at + eff_len)
                text_q.push_back(pat_mem[k - plant_at]);
            else
                text_q.push_back(8'(alpha_lo + $urandom_range(alpha_span)));
        end
        keep_open = ($urandom_range(9) == 0);

        for (int k = 0; k < text_len; k++) begin
            if ($urandom_range(24) == 0) begin
                send_item(fsub_pkg::MODE_LOAD, 8'($urandom_range(255)),
                          fsub_pkg::IDX_W'($urandom_range(63)), 1'($urandom_range(1)));
            end
            send_item(fsub_pkg::MODE_SEARCH, text_q[k], fsub_pkg::IDX_W'($urandom_range(63)),
                      (k == text_len - 1) && !keep_open);
        end
    endtask

    // Random searches under each idle and stall mix
    task automatic test_random_searches();
        int start_cnt;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 47;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 47;
                end
                default: begin
                    send_idle_pct = 33;
                    stall_pct = 33;
                end
            endcase
            start_cnt = n_items;
            while (n_items - start_cnt < PHASE_ITEMS) run_round();
        end
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // Test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_basic_match();
        test_mid_search();
        test_fill_store();
        test_long_pattern();
        test_random_searches();
        wait_idle();

        $display("Sent %0d input transfers and made %0d register writes in %0d cycles.",
                 n_items, n_writes, cycle_cnt);
        $display("Checked %0d match results and %0d no-match results, %0d errors.",
                 n_found, n_missed, err_cnt);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
